### design/ilp_pkg.sv
// ----------------------------------------------------------------------------
// ilp_pkg
// shared types, codes and character constants of the integer literal parser
// ----------------------------------------------------------------------------
package ilp_pkg;

  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_ZERO   = 3'd1;
  localparam logic [2:0] PH_PREFIX = 3'd2;
  localparam logic [2:0] PH_DIGITS = 3'd3;
  localparam logic [2:0] PH_SUFFIX = 3'd4;

  localparam logic [1:0] RX_DEC = 2'd0;
  localparam logic [1:0] RX_BIN = 2'd1;
  localparam logic [1:0] RX_OCT = 2'd2;
  localparam logic [1:0] RX_HEX = 2'd3;

  localparam logic [2:0] TY_INT16  = 3'd0;
  localparam logic [2:0] TY_INT32  = 3'd1;
  localparam logic [2:0] TY_INT64  = 3'd2;
  localparam logic [2:0] TY_UINT16 = 3'd3;
  localparam logic [2:0] TY_UINT32 = 3'd4;
  localparam logic [2:0] TY_UINT64 = 3'd5;

  localparam logic [15:0] CH_0  = 16'h0030;
  localparam logic [15:0] CH_1  = 16'h0031;
  localparam logic [15:0] CH_2  = 16'h0032;
  localparam logic [15:0] CH_3  = 16'h0033;
  localparam logic [15:0] CH_4  = 16'h0034;
  localparam logic [15:0] CH_6  = 16'h0036;
  localparam logic [15:0] CH_9  = 16'h0039;
  localparam logic [15:0] CH_UA = 16'h0041;
  localparam logic [15:0] CH_UB = 16'h0042;
  localparam logic [15:0] CH_UF = 16'h0046;
  localparam logic [15:0] CH_UX = 16'h0058;
  localparam logic [15:0] CH_LA = 16'h0061;
  localparam logic [15:0] CH_LB = 16'h0062;
  localparam logic [15:0] CH_LF = 16'h0066;
  localparam logic [15:0] CH_S  = 16'h0073;
  localparam logic [15:0] CH_U  = 16'h0075;
  localparam logic [15:0] CH_LX = 16'h0078;

  localparam int SUFFIX_KINDS = 6;

  // suffix strings, first character in the high bits, indexed by type code
  localparam logic [47:0] SUFFIX_TAB [SUFFIX_KINDS] = '{
    {CH_S, CH_1, CH_6},
    {CH_S, CH_3, CH_2},
    {CH_S, CH_6, CH_4},
    {CH_U, CH_1, CH_6},
    {CH_U, CH_3, CH_2},
    {CH_U, CH_6, CH_4}
  };

  typedef struct packed {
    logic [2:0]       phase;
    logic [1:0]       radix;
    logic [63:0]      acc;
    logic             ovf;
    logic [2:0]       scount;
    logic [2:0][15:0] schars;
  } ilp_state_t;

  typedef struct packed {
    logic        bad_suffix;
    logic        too_large;
    logic [2:0]  int_type;
    logic [63:0] value;
  } ilp_result_t;

endpackage

### design/ilp_next.sv
// ----------------------------------------------------------------------------
// ilp_next
// per-character state update: prefix detection, digit accumulation, suffix
// ----------------------------------------------------------------------------
module ilp_next (
  input  ilp_pkg::ilp_state_t state,
  input  logic [15:0]         character,
  output ilp_pkg::ilp_state_t state_next
);

  logic        is_num;
  logic        is_alpha;
  logic [3:0]  dv;
  logic [1:0]  eff_radix;
  logic        is_digit;
  logic [67:0] acc_w;
  logic [67:0] prod;
  logic [67:0] sum;
  logic        is_b;
  logic        is_x;

  assign is_num   = (character >= ilp_pkg::CH_0) && (character <= ilp_pkg::CH_9);
  assign is_alpha = ((character >= ilp_pkg::CH_LA) && (character <= ilp_pkg::CH_LF)) ||
                    ((character >= ilp_pkg::CH_UA) && (character <= ilp_pkg::CH_UF));
  assign dv       = is_num ? character[3:0] : 4'(character[3:0] + 4'd9);
  assign is_b     = (character == ilp_pkg::CH_LB) || (character == ilp_pkg::CH_UB);
  assign is_x     = (character == ilp_pkg::CH_LX) || (character == ilp_pkg::CH_UX);

  assign eff_radix = (state.phase == ilp_pkg::PH_ZERO) ? ilp_pkg::RX_OCT : state.radix;

  always_comb begin
    case (eff_radix)
      ilp_pkg::RX_BIN: is_digit = is_num && (dv < 4'd2);
      ilp_pkg::RX_OCT: is_digit = is_num && (dv < 4'd8);
      ilp_pkg::RX_HEX: is_digit = is_num || is_alpha;
      default:         is_digit = is_num;
    endcase
  end

  assign acc_w = {4'b0, state.acc};

  always_comb begin
    case (eff_radix)
      ilp_pkg::RX_BIN: prod = acc_w << 1;
      ilp_pkg::RX_OCT: prod = acc_w << 3;
      ilp_pkg::RX_HEX: prod = acc_w << 4;
      default:         prod = (acc_w << 3) + (acc_w << 1);
    endcase
  end

  assign sum = prod + {64'b0, dv};

  always_comb begin
    logic take_digit;
    logic take_suffix;
    take_digit  = 1'b0;
    take_suffix = 1'b0;
    state_next  = state;
    case (state.phase)
      ilp_pkg::PH_START: begin
        if (character == ilp_pkg::CH_0) begin
          state_next.phase = ilp_pkg::PH_ZERO;
        end else begin
          state_next.radix = ilp_pkg::RX_DEC;
          take_digit  = is_digit;
          take_suffix = !is_digit;
        end
      end
      ilp_pkg::PH_ZERO: begin
        if (is_b) begin
          state_next.radix = ilp_pkg::RX_BIN;
          state_next.phase = ilp_pkg::PH_PREFIX;
        end else if (is_x) begin
          state_next.radix = ilp_pkg::RX_HEX;
          state_next.phase = ilp_pkg::PH_PREFIX;
        end else begin
          state_next.radix = ilp_pkg::RX_OCT;
          take_digit  = is_digit;
          take_suffix = !is_digit;
        end
      end
      ilp_pkg::PH_PREFIX, ilp_pkg::PH_DIGITS: begin
        take_digit  = is_digit;
        take_suffix = !is_digit;
      end
      default: begin
        take_suffix = 1'b1;
      end
    endcase

    if (take_digit) begin
      state_next.phase = ilp_pkg::PH_DIGITS;
      if (!state.ovf) begin
        if (sum[67:64] != 4'b0) begin
          state_next.ovf = 1'b1;
        end else begin
          state_next.acc = sum[63:0];
        end
      end
    end

    if (take_suffix) begin
      state_next.phase = ilp_pkg::PH_SUFFIX;
      if (state.scount < 3'd3) begin
        state_next.schars[state.scount[1:0]] = character;
      end
      if (state.scount < 3'd4) begin
        state_next.scount = 3'(state.scount + 3'd1);
      end
    end
  end

endmodule

### design/ilp_result.sv
// ----------------------------------------------------------------------------
// ilp_result
// end-of-token result: value, type from suffix or magnitude, error flags
// ----------------------------------------------------------------------------
module ilp_result (
  input  ilp_pkg::ilp_state_t  state,
  output ilp_pkg::ilp_result_t result
);

  logic [63:0] value;
  logic [47:0] sfx;

  assign value = state.ovf ? 64'b0 : state.acc;
  assign sfx   = {state.schars[0], state.schars[1], state.schars[2]};

  always_comb begin
    logic hit;
    hit               = 1'b0;
    result.value      = value;
    result.too_large  = state.ovf;
    result.int_type   = ilp_pkg::TY_INT16;
    result.bad_suffix = 1'b0;
    if (state.scount == 3'd0) begin
      if (value[63:31] == 33'b0) begin
        result.int_type = ilp_pkg::TY_INT32;
      end else if (!value[63]) begin
        result.int_type = ilp_pkg::TY_INT64;
      end else begin
        result.int_type = ilp_pkg::TY_UINT64;
      end
    end else if (state.scount == 3'd3) begin
      for (int k = 0; k < ilp_pkg::SUFFIX_KINDS; k++) begin
        if (!hit && (sfx == ilp_pkg::SUFFIX_TAB[k])) begin
          hit             = 1'b1;
          result.int_type = 3'(k);
        end
      end
      result.bad_suffix = !hit;
    end else begin
      result.bad_suffix = 1'b1;
    end
  end

endmodule

### design/integer_literal_parser.sv
// the beat carrying tlast is captured in the input register, then its result is registered
// into m_tdata and m_tvalid once the output is free; throughput: one character beat per
// cycle unless a tlast beat waits on a stalled result; the token state register and its update loop set this rate
// reset: synchronous on rst, clears the token state except schars, and both valid flags
// ----------------------------------------------------------------------------
// integer_literal_parser
// streams one literal token per run of character beats, one result per token
// ----------------------------------------------------------------------------
module integer_literal_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // character
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // value, int_type, too_large, bad_suffix, zero pad
);

  logic                 in_valid;
  logic [15:0]          in_char;
  logic                 in_last;
  logic                 res_free;
  logic                 advance;
  ilp_pkg::ilp_state_t  state;
  ilp_pkg::ilp_state_t  state_next;
  ilp_pkg::ilp_result_t result;

  assign res_free = !m_tvalid || m_tready;
  assign advance  = in_valid && (!in_last || res_free);
  assign s_tready = !in_valid || advance;

  ilp_next u_next (
    .state      (state),
    .character  (in_char),
    .state_next (state_next)
  );

  ilp_result u_result (
    .state  (state_next),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      m_tvalid     <= 1'b0;
      state.phase  <= ilp_pkg::PH_START;
      state.radix  <= ilp_pkg::RX_DEC;
      state.acc    <= 64'b0;
      state.ovf    <= 1'b0;
      state.scount <= 3'd0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        state.schars <= state_next.schars;
        if (in_last) begin
          state.phase  <= ilp_pkg::PH_START;
          state.radix  <= ilp_pkg::RX_DEC;
          state.acc    <= 64'b0;
          state.ovf    <= 1'b0;
          state.scount <= 3'd0;
        end else begin
          state.phase  <= state_next.phase;
          state.radix  <= state_next.radix;
          state.acc    <= state_next.acc;
          state.ovf    <= state_next.ovf;
          state.scount <= state_next.scount;
        end
      end
      if (advance && in_last) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
    if (advance && in_last) begin
      m_tdata <= {3'b0, result};
    end
  end

endmodule

### design/ilp_checker.sv
// ----------------------------------------------------------------------------
// ilp_checker
// port-level checks of the integer literal parser result stream
// ----------------------------------------------------------------------------
module ilp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_type_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[66:64] == ilp_pkg::TY_INT16) ||
                 (m_tdata[66:64] == ilp_pkg::TY_INT32) ||
                 (m_tdata[66:64] == ilp_pkg::TY_INT64) ||
                 (m_tdata[66:64] == ilp_pkg::TY_UINT16) ||
                 (m_tdata[66:64] == ilp_pkg::TY_UINT32) ||
                 (m_tdata[66:64] == ilp_pkg::TY_UINT64))
    else $error("type code out of range");

  a_large_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[67] |-> m_tdata[63:0] == 64'b0)
    else $error("too large literal with nonzero value");

  a_bad_int16: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[68] |-> m_tdata[66:64] == ilp_pkg::TY_INT16)
    else $error("bad suffix without int16 type");

endmodule

bind integer_literal_parser ilp_checker u_ilp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
